FILE: hdl/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg
// Shared opcodes, status codes and pipeline control record for the ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [3:0] {
    OP_CMP  = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_QUOT = 4'd4,
    OP_REM  = 4'd5,
    OP_AND  = 4'd6,
    OP_OR   = 4'd7,
    OP_XOR  = 4'd8,
    OP_SHL  = 4'd9,
    OP_SHR  = 4'd10
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_DIVZ  = 2'd2,
    ST_SHIFT = 2'd3
  } status_e;

  typedef struct packed {
    logic    valid;
    op_e     op;
    logic    sa;
    logic    sb;
    logic    divz;
    logic    qovf;
    status_e fast_st;
  } ctl_t;

endpackage

FILE: hdl/cia_div_stage.sv
// ----------------------------------------------------------------------------
// cia_div_stage
// One registered step of a restoring unsigned divider: one quotient bit.
// ----------------------------------------------------------------------------
module cia_div_stage #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] quo_i,
  input  logic [W-1:0] den_i,
  output logic [W-1:0] num_o,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] den_o
);
  logic [W-1:0] trial;
  logic         ge;
  logic [W-1:0] num_d, rem_d, quo_d;
  logic [W-1:0] num_q, rem_q, quo_q, den_q;

  always_comb begin
    trial = {rem_i[W-2:0], num_i[W-1]};
    ge    = (trial >= den_i);
    rem_d = ge ? (trial - den_i) : trial;
    quo_d = {quo_i[W-2:0], ge};
    num_d = {num_i[W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_i;
  end

  assign num_o = num_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign den_o = den_q;
endmodule

FILE: hdl/cia_mul.sv
// ----------------------------------------------------------------------------
// cia_mul
// Unsigned magnitude multiplier: registered half-width partial products, then
// a sum, then a delay line of registers that holds the product back.
// ----------------------------------------------------------------------------
module cia_mul #(
  parameter int W     = 32,
  parameter int DEPTH = 32
) (
  input  logic           clk_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] p_o
);
  localparam int H = (W + 1) / 2;

  logic [2*H-1:0] a_ext, b_ext;
  logic [2*H-1:0] pp_ll_d, pp_lh_d, pp_hl_d, pp_hh_d;
  logic [2*H-1:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic [4*H-1:0] sum_d;
  logic [2*W-1:0] line_q [DEPTH-1];

  always_comb begin
    a_ext   = {{(2*H-W){1'b0}}, a_i};
    b_ext   = {{(2*H-W){1'b0}}, b_i};
    pp_ll_d = a_ext[H-1:0]   * b_ext[H-1:0];
    pp_lh_d = a_ext[H-1:0]   * b_ext[2*H-1:H];
    pp_hl_d = a_ext[2*H-1:H] * b_ext[H-1:0];
    pp_hh_d = a_ext[2*H-1:H] * b_ext[2*H-1:H];
    sum_d   = {pp_hh_q, {(2*H){1'b0}}}
            + {{H{1'b0}}, pp_lh_q, {H{1'b0}}}
            + {{H{1'b0}}, pp_hl_q, {H{1'b0}}}
            + {{(2*H){1'b0}}, pp_ll_q};
  end

  always_ff @(posedge clk_i) begin
    pp_ll_q   <= pp_ll_d;
    pp_lh_q   <= pp_lh_d;
    pp_hl_q   <= pp_hl_d;
    pp_hh_q   <= pp_hh_d;
    line_q[0] <= sum_d[2*W-1:0];
    for (int k = 1; k < DEPTH - 1; k++) begin
      line_q[k] <= line_q[k-1];
    end
  end

  assign p_o = line_q[DEPTH-2];
endmodule

FILE: hdl/checked_int32_alu.sv
// ----------------------------------------------------------------------------
// checked_int32_alu
// Pipelined checked signed integer ALU with overflow, zero-divisor and
// shift-range status.
// ----------------------------------------------------------------------------
// Usage:
//   Drive op_i, left_operand_i and right_operand_i with start_i high; the
//   item is taken at that clock edge. busy_o stays low: a new item may be
//   given in every cycle.
//   Each item yields one result: result_value_o and status_o are shown for
//   one cycle with done_o high. Throughput is one item per cycle. The
//   pipeline depth is set by the divider, one quotient bit per stage over
//   DATA_WIDTH stages, plus an operand stage and an output stage; the
//   multiplier's product is delayed to match.
//   Results leave in input order. The receiver cannot stall: a result that
//   is not taken in its cycle is gone.
//   Reset clears all valid bits; items in flight are dropped.
//   A flagged status always comes with a zero result value.
// ----------------------------------------------------------------------------
module checked_int32_alu #(
  parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [3:0]            op_i,
  input  logic [DATA_WIDTH-1:0] left_operand_i,
  input  logic [DATA_WIDTH-1:0] right_operand_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] result_value_o,
  output logic [1:0]            status_o
);
  import cia_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int LAT = W + 2;
  localparam logic [W-1:0]   SIGN_W = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W-1:0] SIGN_P = {{W{1'b0}}, SIGN_W};

  logic [W-1:0] a, b, ma_d, mb_d, fast_r_d;
  logic [W-1:0] sum_ab, dif_ab;
  ctl_t         ctl_d;
  op_e          op_in;

  logic [W-1:0] ma_q, mb_q;
  ctl_t         ctl_q  [W+1];
  logic [W-1:0] fast_q [W+1];

  logic [W-1:0] num_s [W+1];
  logic [W-1:0] rem_s [W+1];
  logic [W-1:0] quo_s [W+1];
  logic [W-1:0] den_s [W+1];
  logic [2*W-1:0] prod;

  logic [W-1:0] res_d, res_q;
  status_e      st_d, st_q;
  logic         done_q;
  logic         neg_m;
  ctl_t         cf;

  // operand stage
  always_comb begin
    a       = left_operand_i;
    b       = right_operand_i;
    op_in   = op_e'(op_i);
    ma_d    = a[W-1] ? (~a + 1'b1) : a;
    mb_d    = b[W-1] ? (~b + 1'b1) : b;
    sum_ab  = a + b;
    dif_ab  = a - b;
    fast_r_d = '0;
    ctl_d          = '0;
    ctl_d.valid    = start_i;
    ctl_d.op       = op_in;
    ctl_d.sa       = a[W-1];
    ctl_d.sb       = b[W-1];
    ctl_d.divz     = (b == '0);
    ctl_d.qovf     = (a == SIGN_W) && (b == '1);
    ctl_d.fast_st  = ST_OK;
    case (op_in)
      OP_CMP: begin
        if ($signed(a) < $signed(b)) fast_r_d = '1;
        else if ($signed(a) > $signed(b)) fast_r_d = {{(W-1){1'b0}}, 1'b1};
      end
      OP_ADD: begin
        fast_r_d = sum_ab;
        if (a[W-1] == b[W-1] && sum_ab[W-1] != a[W-1]) ctl_d.fast_st = ST_OVF;
      end
      OP_SUB: begin
        fast_r_d = dif_ab;
        if (a[W-1] != b[W-1] && dif_ab[W-1] != a[W-1]) ctl_d.fast_st = ST_OVF;
      end
      OP_AND: fast_r_d = a & b;
      OP_OR:  fast_r_d = a | b;
      OP_XOR: fast_r_d = a ^ b;
      OP_SHL, OP_SHR: begin
        if (b[W-1] || b > (W - 1)) ctl_d.fast_st = ST_SHIFT;
        else if (op_in == OP_SHL) fast_r_d = a << b;
        else fast_r_d = $signed(a) >>> b;
      end
      default: fast_r_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= W; k++) begin
        ctl_q[k] <= '0;
      end
    end else begin
      ctl_q[0] <= ctl_d;
      for (int k = 1; k <= W; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q      <= ma_d;
    mb_q      <= mb_d;
    fast_q[0] <= fast_r_d;
    for (int k = 1; k <= W; k++) begin
      fast_q[k] <= fast_q[k-1];
    end
  end

  // divider
  assign num_s[0] = ma_q;
  assign rem_s[0] = '0;
  assign quo_s[0] = '0;
  assign den_s[0] = mb_q;

  for (genvar g = 0; g < W; g++) begin : g_div
    cia_div_stage #(.W(W)) u_stage (
      .clk_i (clk_i),
      .num_i (num_s[g]),
      .rem_i (rem_s[g]),
      .quo_i (quo_s[g]),
      .den_i (den_s[g]),
      .num_o (num_s[g+1]),
      .rem_o (rem_s[g+1]),
      .quo_o (quo_s[g+1]),
      .den_o (den_s[g+1])
    );
  end

  cia_mul #(.W(W), .DEPTH(W)) u_mul (
    .clk_i (clk_i),
    .a_i   (ma_q),
    .b_i   (mb_q),
    .p_o   (prod)
  );

  // output stage
  always_comb begin
    cf    = ctl_q[W];
    neg_m = cf.sa ^ cf.sb;
    res_d = fast_q[W];
    st_d  = cf.fast_st;
    case (cf.op)
      OP_MUL: begin
        if (neg_m ? (prod > SIGN_P) : (prod > SIGN_P - 1'b1)) st_d = ST_OVF;
        else res_d = neg_m ? (~prod[W-1:0] + 1'b1) : prod[W-1:0];
      end
      OP_QUOT: begin
        if (cf.divz) st_d = ST_DIVZ;
        else if (cf.qovf) st_d = ST_OVF;
        else res_d = neg_m ? (~quo_s[W] + 1'b1) : quo_s[W];
      end
      OP_REM: begin
        if (cf.divz) st_d = ST_DIVZ;
        else res_d = cf.sa ? (~rem_s[W] + 1'b1) : rem_s[W];
      end
      default: res_d = fast_q[W];
    endcase
    if (st_d != ST_OK) res_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cf.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    st_q  <= st_d;
  end

  assign busy_o         = 1'b0;
  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign status_o       = st_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("result missing at expected latency");
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result without a matching item");
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (result_value_o == '0))
    else $error("flagged result is not zero");
`endif
endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the checked 32-bit integer ALU: a table of directed
// items, then random items in three pacing phases, all scored in order
// against a behavioral predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import cia_pkg::*;

  localparam int W = 32;
  localparam logic [W-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [W-1:0] INT_MAX = 32'h7fff_ffff;
  localparam logic [W-1:0] NEG_ONE = 32'hffff_ffff;
  localparam int N_RAND = 1950;
  localparam int LATENCY = W + 2;

  typedef struct {
    logic [3:0]   op;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         known;
    logic [W-1:0] r;
    logic [1:0]   st;
  } row_t;

  typedef struct {
    logic [W-1:0] r;
    logic [1:0]   st;
  } alu_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [3:0] op_i = '0;
  logic [W-1:0] left_operand_i = '0;
  logic [W-1:0] right_operand_i = '0;
  logic busy_o, done_o;
  logic [W-1:0] result_value_o;
  logic [1:0] status_o;

  alu_res_t pending_q[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int st_seen[4];

  checked_int32_alu u_dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("timeout at %0t", $time);
    $display("== FAIL ==");
    $finish;
  end

  function automatic alu_res_t alu_predict(logic [3:0] op, logic [W-1:0] a,
                                           logic [W-1:0] b);
    alu_res_t res;
    logic signed [W-1:0] sa, sb;
    longint p, x, y;
    sa = a;
    sb = b;
    x = sa;
    y = sb;
    res.r = '0;
    res.st = ST_OK;
    case (op)
      OP_CMP: res.r = (sa < sb) ? NEG_ONE : (sa > sb) ? 32'd1 : 32'd0;
      OP_ADD: begin
        p = x + y;
        res.r = p[W-1:0];
        if (p > 64'sd2147483647 || p < -64'sd2147483648) res.st = ST_OVF;
      end
      OP_SUB: begin
        p = x - y;
        res.r = p[W-1:0];
        if (p > 64'sd2147483647 || p < -64'sd2147483648) res.st = ST_OVF;
      end
      OP_MUL: begin
        p = x * y;
        res.r = p[W-1:0];
        if (p > 64'sd2147483647 || p < -64'sd2147483648) res.st = ST_OVF;
      end
      OP_QUOT: begin
        if (b == 0) res.st = ST_DIVZ;
        else if (a == INT_MIN && b == NEG_ONE) res.st = ST_OVF;
        else begin
          p = x / y;
          res.r = p[W-1:0];
        end
      end
      OP_REM: begin
        if (b == 0) res.st = ST_DIVZ;
        else begin
          p = x % y;
          res.r = p[W-1:0];
        end
      end
      OP_AND: res.r = a & b;
      OP_OR:  res.r = a | b;
      OP_XOR: res.r = a ^ b;
      OP_SHL, OP_SHR: begin
        if (sb < 0 || sb > W - 1) res.st = ST_SHIFT;
        else if (op == OP_SHL) res.r = a << b[4:0];
        else res.r = sa >>> b[4:0];
      end
      default: ;
    endcase
    if (res.st != ST_OK) res.r = '0;
    return res;
  endfunction

  // drive one item, honoring busy; gap_pct is the sender idle rate
  task automatic send_item(logic [3:0] op, logic [W-1:0] a, logic [W-1:0] b,
                           int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    op_i <= op;
    left_operand_i <= a;
    right_operand_i <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_q.push_back(alu_predict(op, a, b));
    n_items++;
  endtask

  always @(posedge clk_i) begin
    alu_res_t exp_r;
    if (rst_ni && done_o) begin
      n_results++;
      st_seen[status_o]++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result r=%h st=%0d", $time, result_value_o,
                 status_o);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (result_value_o !== exp_r.r) begin
          $display("%0t: result_value exp %h got %h", $time, exp_r.r,
                   result_value_o);
          errors++;
        end
        if (status_o !== exp_r.st) begin
          $display("%0t: status exp %0d got %0d", $time, exp_r.st, status_o);
          errors++;
        end
      end
    end
  end

  function automatic logic [W-1:0] rand_operand();
    case ($urandom_range(5))
      0: return INT_MIN;
      1: return INT_MAX;
      2: return $urandom_range(0, 1) ? NEG_ONE : '0;
      3: return W'($signed($urandom_range(0, 80)) - 40);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [W-1:0] rand_right(logic [3:0] op);
    if ((op == OP_SHL || op == OP_SHR) && $urandom_range(9) < 7)
      return $urandom_range(0, W - 1);
    if (op == OP_MUL && $urandom_range(1)) return $urandom_range(0, 65535);
    return rand_operand();
  endfunction

  row_t dir_rows[] = '{
    '{OP_CMP,  INT_MIN, INT_MAX, 1, NEG_ONE, ST_OK},
    '{OP_CMP,  INT_MAX, INT_MIN, 1, 32'd1,   ST_OK},
    '{OP_CMP,  32'd5,   32'd5,   1, 32'd0,   ST_OK},
    '{OP_ADD,  INT_MAX, 32'd1,   1, 32'd0,   ST_OVF},
    '{OP_ADD,  INT_MIN, NEG_ONE, 1, 32'd0,   ST_OVF},
    '{OP_ADD,  32'd7,   NEG_ONE, 0, 0, 0},
    '{OP_SUB,  INT_MIN, 32'd1,   1, 32'd0,   ST_OVF},
    '{OP_SUB,  32'd0,   INT_MIN, 1, 32'd0,   ST_OVF},
    '{OP_SUB,  32'd3,   32'd10,  0, 0, 0},
    '{OP_MUL,  INT_MIN, NEG_ONE, 1, 32'd0,   ST_OVF},
    '{OP_MUL,  INT_MIN, 32'd1,   1, INT_MIN, ST_OK},
    '{OP_MUL,  32'h10000, 32'h8000, 0, 0, 0},
    '{OP_QUOT, INT_MIN, NEG_ONE, 1, 32'd0,   ST_OVF},
    '{OP_QUOT, 32'd9,   32'd0,   1, 32'd0,   ST_DIVZ},
    '{OP_QUOT, 32'hfffffff9, 32'd2, 0, 0, 0},
    '{OP_REM,  INT_MIN, NEG_ONE, 1, 32'd0,   ST_OK},
    '{OP_REM,  32'd9,   32'd0,   1, 32'd0,   ST_DIVZ},
    '{OP_REM,  32'hfffffff9, 32'd2, 0, 0, 0},
    '{OP_AND,  NEG_ONE, INT_MIN, 1, INT_MIN, ST_OK},
    '{OP_OR,   INT_MAX, INT_MIN, 1, NEG_ONE, ST_OK},
    '{OP_XOR,  NEG_ONE, INT_MAX, 1, INT_MIN, ST_OK},
    '{OP_SHL,  32'd1,   32'd31,  1, INT_MIN, ST_OK},
    '{OP_SHL,  32'd1,   32'd32,  1, 32'd0,   ST_SHIFT},
    '{OP_SHR,  INT_MIN, 32'd31,  1, NEG_ONE, ST_OK},
    '{OP_SHR,  32'd1,   NEG_ONE, 1, 32'd0,   ST_SHIFT},
    '{4'd13,   NEG_ONE, NEG_ONE, 1, 32'd0,   ST_OK}
  };

  initial begin
    alu_res_t chk;
    int gap, wait_cyc;
    logic [3:0] op;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) begin
        chk = alu_predict(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b);
        if (chk.r !== dir_rows[i].r || chk.st !== dir_rows[i].st) begin
          $display("%0t: table row %0d exp %h/%0d predictor %h/%0d", $time, i,
                   dir_rows[i].r, dir_rows[i].st, chk.r, chk.st);
          errors++;
        end
      end
      send_item(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, 0);
    end
    for (int i = 0; i < N_RAND; i++) begin
      gap = (i < N_RAND / 3) ? 11 : (i < 2 * N_RAND / 3) ? 73 : 0;
      op = ($urandom_range(19) == 0) ? 4'($urandom_range(11, 15))
                                     : 4'($urandom_range(0, 10));
      send_item(op, rand_operand(), rand_right(op), gap);
    end
    start_i <= 1'b0;
    wait_cyc = 0;
    while (pending_q.size() != 0 && wait_cyc < 20 * LATENCY) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    repeat (LATENCY) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_q.size());
      errors++;
    end
    $display("sent %0d items, scored %0d results", n_items, n_results);
    $display("status mix ok/ovf/divz/shift: %0d/%0d/%0d/%0d", st_seen[0],
             st_seen[1], st_seen[2], st_seen[3]);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
